// File: design/hprl_pkg.sv
`default_nettype none
package hprl_pkg;

	localparam int SUB_DEPTH = 1024;
	localparam int SRC_DEPTH = 8192;
	localparam int SUB_AW = (SUB_DEPTH > 1) ? $clog2(SUB_DEPTH) : 1;
	localparam int SRC_AW = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;
	localparam int SUB_FW = SUB_AW + 1;
	localparam int SRC_FW = SRC_AW + 1;
	localparam int IDX_W = (SUB_FW > SRC_FW) ? SUB_FW : SRC_FW;

	localparam int RATE_W = 30;
	localparam int DIV_CW = $clog2(RATE_W);

	localparam logic [63:0] WINDOW_NS = 64'd1000000000;
	localparam logic [RATE_W-1:0] DIVIDEND = RATE_W'(1000000000);
	localparam logic [31:0] SUBNET_MASK = 32'hFFFFFF00;
	localparam logic [31:0] RST_GLOBAL_LIMIT = 32'd50000;
	localparam logic [31:0] RST_SUBNET_LIMIT = 32'd5000;
	localparam logic [RATE_W-1:0] RST_IP_RATE = RATE_W'(1000);

	localparam logic [1:0] CFG_GLOBAL = 2'd0;
	localparam logic [1:0] CFG_SUBNET = 2'd1;
	localparam logic [1:0] CFG_RATE = 2'd2;

	typedef enum logic [1:0] {
		RSN_PASS = 2'd0,
		RSN_GLOBAL = 2'd1,
		RSN_SUBNET = 2'd2,
		RSN_SOURCE = 2'd3
	} reason_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GLOBAL,
		ST_SCAN,
		ST_SUB_UPD,
		ST_SRC_WAIT,
		ST_SRC_UPD
	} state_t;

	typedef enum logic {
		TBL_SUB,
		TBL_SRC
	} tbl_t;

	typedef struct packed {
		logic [23:0] key;
		logic [31:0] count;
		logic [63:0] start;
		logic [63:0] stamp;
	} sub_entry_t;

	typedef struct packed {
		logic [31:0] addr;
		logic [63:0] last;
		logic [63:0] stamp;
	} src_entry_t;

	localparam int SUB_EW = $bits(sub_entry_t);
	localparam int SRC_EW = $bits(src_entry_t);

endpackage
`default_nettype wire

// File: design/hprl_ram.sv
`default_nettype none
module hprl_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: design/hprl_div.sv
`default_nettype none
module hprl_div import hprl_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [RATE_W-1:0] divisor,
	output logic [RATE_W-1:0] quot,
	output logic valid
);

	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] quot_q;
	logic [RATE_W-1:0] den_q;
	logic [DIV_CW-1:0] cnt_q;
	logic run_q;
	logic valid_q;

	logic [RATE_W:0] trial;
	logic [RATE_W:0] trial_sub;
	logic take;

	assign trial = {rem_q, quot_q[RATE_W-1]};
	assign take = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CW'(RATE_W - 1)) begin
				run_q <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quot_q <= DIVIDEND;
			den_q <= (divisor == '0) ? RATE_W'(1) : divisor;
		end else if (run_q) begin
			rem_q <= take ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
			quot_q <= {quot_q[RATE_W-2:0], take};
		end
	end

	assign quot = quot_q;
	assign valid = valid_q;

endmodule
`default_nettype wire

// File: design/hierarchical_packet_rate_limiter.sv
// channel   | handshake                     | payload
// request   | start, busy                   | src_addr[31:0], now_ns[63:0]
// result    | done (one-cycle strobe)       | drop, drop_reason[1:0]
// config    | cfg_valid, cfg_ready (tied 1) | cfg_index[1:0], cfg_data[31:0]
//
// one request at a time; busy covers the global check, the subnet scan (shorter on a hit),
// the subnet update, a wait on the spacing divider started at accept, the source scan and the
// source update; a global or subnet drop ends the request early. done is registered from fin.
// each table is searched one entry per cycle through its single read port.
// after reset both tables are empty through fill counts; there is no clearing pass.
// results are strobed once and cannot be stalled.
`default_nettype none
module hierarchical_packet_rate_limiter import hprl_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [31:0] src_addr,
	input wire logic [63:0] now_ns,
	output logic done,
	output logic drop,
	output logic [1:0] drop_reason,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);

	state_t state_q, state_d;
	tbl_t tbl_q;

	logic [31:0] glimit_q, slimit_q;
	logic [RATE_W-1:0] rate_q;
	logic [31:0] gcount_q;
	logic [63:0] gstart_q;
	logic [63:0] use_q;
	logic [SUB_FW-1:0] sub_fill_q;
	logic [SRC_FW-1:0] src_fill_q;

	logic [31:0] addr_q;
	logic [63:0] now_q;

	logic [IDX_W-1:0] issue_q, pidx_s1, victim_q, slot_q;
	logic pend_s1, hit_q;
	logic [63:0] oldest_q;
	sub_entry_t sub_hit_q;
	src_entry_t src_hit_q;

	logic done_q, drop_q;
	reason_t reason_q;

	sub_entry_t sub_rd, sub_wr;
	src_entry_t src_rd, src_wr;
	logic sub_re, src_re, sub_we, src_we;

	logic div_start, div_valid;
	logic [RATE_W-1:0] spacing;

	logic [63:0] gdiff;
	logic g_restart, g_fail;
	logic [31:0] g_inc;

	logic [IDX_W-1:0] scan_fill;
	logic scan_full, rd_match, stamp_better, scan_hit, scan_miss, scan_rd, scan_init;
	logic [63:0] rd_stamp;
	logic [IDX_W-1:0] victim_d, miss_slot;

	logic [63:0] sdiff, ldiff;
	logic s_restart, s_fail, l_fail;
	logic [31:0] s_inc;

	logic fin;
	reason_t fin_reason;

	hprl_ram #(.DEPTH(SUB_DEPTH), .WIDTH(SUB_EW)) u_sub_ram (
		.clk(clk),
		.we(sub_we),
		.waddr(slot_q[SUB_AW-1:0]),
		.wdata(sub_wr),
		.re(sub_re),
		.raddr(issue_q[SUB_AW-1:0]),
		.rdata(sub_rd)
	);

	hprl_ram #(.DEPTH(SRC_DEPTH), .WIDTH(SRC_EW)) u_src_ram (
		.clk(clk),
		.we(src_we),
		.waddr(slot_q[SRC_AW-1:0]),
		.wdata(src_wr),
		.re(src_re),
		.raddr(issue_q[SRC_AW-1:0]),
		.rdata(src_rd)
	);

	hprl_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.divisor(rate_q),
		.quot(spacing),
		.valid(div_valid)
	);

	// global window
	assign gdiff = now_q - gstart_q;
	assign g_restart = gdiff > WINDOW_NS;
	assign g_inc = (gcount_q == '1) ? gcount_q : gcount_q + 32'd1;
	assign g_fail = !g_restart && (g_inc > glimit_q);

	// table scan
	assign scan_fill = (tbl_q == TBL_SUB) ? IDX_W'(sub_fill_q) : IDX_W'(src_fill_q);
	assign scan_full = (tbl_q == TBL_SUB) ? (scan_fill == IDX_W'(SUB_DEPTH))
		: (scan_fill == IDX_W'(SRC_DEPTH));
	assign rd_match = (tbl_q == TBL_SUB) ? (sub_rd.key == addr_q[31:8])
		: (src_rd.addr == addr_q);
	assign rd_stamp = (tbl_q == TBL_SUB) ? sub_rd.stamp : src_rd.stamp;
	assign stamp_better = pend_s1 && (rd_stamp < oldest_q);
	assign victim_d = stamp_better ? pidx_s1 : victim_q;
	assign scan_hit = (state_q == ST_SCAN) && pend_s1 && rd_match;
	assign scan_miss = (state_q == ST_SCAN) && !scan_hit
		&& ((pend_s1 && (pidx_s1 == scan_fill - 1'b1)) || (!pend_s1 && scan_fill == '0));
	assign miss_slot = scan_full ? victim_d : scan_fill;
	assign scan_rd = (state_q == ST_SCAN) && (issue_q < scan_fill) && !scan_hit && !scan_miss;
	assign sub_re = scan_rd && (tbl_q == TBL_SUB);
	assign src_re = scan_rd && (tbl_q == TBL_SRC);

	// subnet update
	assign sdiff = now_q - sub_hit_q.start;
	assign s_restart = sdiff > WINDOW_NS;
	assign s_inc = (sub_hit_q.count == '1) ? sub_hit_q.count : sub_hit_q.count + 32'd1;
	assign s_fail = hit_q && !s_restart && (s_inc > slimit_q);
	always_comb begin
		sub_wr.key = addr_q[31:8];
		sub_wr.count = (!hit_q || s_restart) ? 32'd1 : s_inc;
		sub_wr.start = (!hit_q || s_restart) ? now_q : sub_hit_q.start;
		sub_wr.stamp = use_q + 64'd1;
	end

	// source update
	assign ldiff = now_q - src_hit_q.last;
	assign l_fail = hit_q && (ldiff < {{(64-RATE_W){1'b0}}, spacing});
	always_comb begin
		src_wr.addr = addr_q;
		src_wr.last = l_fail ? src_hit_q.last : now_q;
		src_wr.stamp = use_q + 64'd1;
	end

	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		scan_init = 1'b0;
		sub_we = 1'b0;
		src_we = 1'b0;
		fin = 1'b0;
		fin_reason = RSN_PASS;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					div_start = 1'b1;
					state_d = ST_GLOBAL;
				end
			end
			ST_GLOBAL: begin
				if (g_fail) begin
					fin = 1'b1;
					fin_reason = RSN_GLOBAL;
					state_d = ST_IDLE;
				end else begin
					scan_init = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_hit || scan_miss) begin
					state_d = (tbl_q == TBL_SUB) ? ST_SUB_UPD : ST_SRC_UPD;
				end
			end
			ST_SUB_UPD: begin
				sub_we = 1'b1;
				if (s_fail) begin
					fin = 1'b1;
					fin_reason = RSN_SUBNET;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SRC_WAIT;
				end
			end
			ST_SRC_WAIT: begin
				if (div_valid) begin
					scan_init = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SRC_UPD: begin
				src_we = 1'b1;
				fin = 1'b1;
				fin_reason = l_fail ? RSN_SOURCE : RSN_PASS;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tbl_q <= TBL_SUB;
			glimit_q <= RST_GLOBAL_LIMIT;
			slimit_q <= RST_SUBNET_LIMIT;
			rate_q <= RST_IP_RATE;
			gcount_q <= '0;
			gstart_q <= '0;
			use_q <= '0;
			sub_fill_q <= '0;
			src_fill_q <= '0;
			pend_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= scan_rd;
			done_q <= fin;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_GLOBAL: glimit_q <= cfg_data;
					CFG_SUBNET: slimit_q <= cfg_data;
					CFG_RATE: rate_q <= cfg_data[RATE_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == ST_GLOBAL) begin
				gcount_q <= g_restart ? 32'd1 : g_inc;
				gstart_q <= g_restart ? now_q : gstart_q;
				tbl_q <= TBL_SUB;
			end
			if (state_q == ST_SRC_WAIT) begin
				tbl_q <= TBL_SRC;
			end
			if (sub_we) begin
				use_q <= use_q + 64'd1;
				if (!hit_q && sub_fill_q != SUB_FW'(SUB_DEPTH)) begin
					sub_fill_q <= sub_fill_q + 1'b1;
				end
			end
			if (src_we) begin
				use_q <= use_q + 64'd1;
				if (!hit_q && src_fill_q != SRC_FW'(SRC_DEPTH)) begin
					src_fill_q <= src_fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			addr_q <= src_addr;
			now_q <= now_ns;
		end
		if (scan_init) begin
			issue_q <= '0;
			oldest_q <= '1;
			victim_q <= '0;
		end else begin
			if (scan_rd) begin
				issue_q <= issue_q + 1'b1;
			end
			if (stamp_better) begin
				oldest_q <= rd_stamp;
				victim_q <= pidx_s1;
			end
		end
		pidx_s1 <= issue_q;
		if (scan_hit) begin
			hit_q <= 1'b1;
			slot_q <= pidx_s1;
			sub_hit_q <= sub_rd;
			src_hit_q <= src_rd;
		end else if (scan_miss) begin
			hit_q <= 1'b0;
			slot_q <= miss_slot;
		end
		if (fin) begin
			drop_q <= (fin_reason != RSN_PASS);
			reason_q <= fin_reason;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign drop = drop_q;
	assign drop_reason = reason_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe longer than one cycle");
	a_drop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (drop_q == (reason_q != RSN_PASS))) else $error("drop and reason disagree");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request accepted but not busy");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(sub_fill_q <= SUB_FW'(SUB_DEPTH)) && (src_fill_q <= SRC_FW'(SRC_DEPTH)))
		else $error("fill count past table depth");

endmodule
`default_nettype wire

// File: sim/hierarchical_packet_rate_limiter_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module hierarchical_packet_rate_limiter_tb import hprl_pkg::*;;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [31:0] src_addr;
	logic [63:0] now_ns;
	logic done;
	logic drop;
	logic [1:0] drop_reason;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	hierarchical_packet_rate_limiter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.src_addr(src_addr),
		.now_ns(now_ns),
		.done(done),
		.drop(drop),
		.drop_reason(drop_reason),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// limiter copy kept by the testbench
	logic [31:0] lim_global;
	logic [31:0] lim_subnet;
	logic [RATE_W-1:0] lim_rate;
	logic [31:0] glb_count;
	logic [63:0] glb_start;
	logic [63:0] recency;
	logic [23:0] sub_key [SUB_DEPTH];
	logic [31:0] sub_count [SUB_DEPTH];
	logic [63:0] sub_start [SUB_DEPTH];
	logic [63:0] sub_stamp [SUB_DEPTH];
	int sub_fill;
	logic [31:0] src_key [SRC_DEPTH];
	logic [63:0] src_last [SRC_DEPTH];
	logic [63:0] src_stamp [SRC_DEPTH];
	int src_fill;

	reason_t verdict_q[$];
	int errors;
	logic [63:0] clock_ns;
	logic [31:0] host_pool [96];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("hierarchical_packet_rate_limiter_tb NOT OK");
		$finish;
	end

	// fixed window step, returns 1 when the window limit is exceeded
	function automatic bit window_over(ref logic [31:0] cnt, ref logic [63:0] wstart,
		input logic [63:0] t, input logic [31:0] limit);
		if (t - wstart > WINDOW_NS) begin
			cnt = 32'd1;
			wstart = t;
			return 1'b0;
		end
		if (cnt != 32'hFFFFFFFF)
			cnt = cnt + 32'd1;
		return cnt > limit;
	endfunction

	function automatic reason_t judge_packet(logic [31:0] addr, logic [63:0] t);
		int i;
		int slot;
		logic [63:0] oldest;
		logic [63:0] spacing;
		logic [RATE_W-1:0] rate;
		if (window_over(glb_count, glb_start, t, lim_global))
			return RSN_GLOBAL;
		recency = recency + 64'd1;
		slot = -1;
		for (i = 0; i < sub_fill; i++)
			if (sub_key[i] == addr[31:8])
				slot = i;
		if (slot >= 0) begin
			sub_stamp[slot] = recency;
			if (window_over(sub_count[slot], sub_start[slot], t, lim_subnet))
				return RSN_SUBNET;
		end else begin
			if (sub_fill < SUB_DEPTH) begin
				slot = sub_fill;
				sub_fill++;
			end else begin
				oldest = '1;
				for (i = 0; i < SUB_DEPTH; i++)
					if (sub_stamp[i] < oldest) begin
						oldest = sub_stamp[i];
						slot = i;
					end
			end
			sub_key[slot] = addr[31:8];
			sub_count[slot] = 32'd1;
			sub_start[slot] = t;
			sub_stamp[slot] = recency;
		end
		recency = recency + 64'd1;
		rate = (lim_rate == 0) ? RATE_W'(1) : lim_rate;
		spacing = WINDOW_NS / 64'(rate);
		slot = -1;
		for (i = 0; i < src_fill; i++)
			if (src_key[i] == addr)
				slot = i;
		if (slot >= 0) begin
			src_stamp[slot] = recency;
			if (t - src_last[slot] < spacing)
				return RSN_SOURCE;
			src_last[slot] = t;
			return RSN_PASS;
		end
		if (src_fill < SRC_DEPTH) begin
			slot = src_fill;
			src_fill++;
		end else begin
			oldest = '1;
			for (i = 0; i < SRC_DEPTH; i++)
				if (src_stamp[i] < oldest) begin
					oldest = src_stamp[i];
					slot = i;
				end
		end
		src_key[slot] = addr;
		src_last[slot] = t;
		src_stamp[slot] = recency;
		return RSN_PASS;
	endfunction

	always @(posedge clk) begin
		reason_t want;
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				$error("verdict with no request pending");
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (drop !== (want != RSN_PASS)) begin
					$error("drop expected %0d actual %0d", want != RSN_PASS, drop);
					errors++;
				end
				if (drop_reason !== want) begin
					$error("drop_reason expected %0d actual %0d", want, drop_reason);
					errors++;
				end
			end
		end
	end

	task automatic idle_gap();
		int n;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: n = 0;
			9: n = $urandom_range(20, 200);
			default: n = $urandom_range(1, 4);
		endcase
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_packet(logic [31:0] addr, logic [63:0] t);
		start <= 1'b1;
		src_addr <= addr;
		now_ns <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		verdict_q.push_back(judge_packet(addr, t));
		idle_gap();
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_GLOBAL: lim_global = value;
			CFG_SUBNET: lim_subnet = value;
			CFG_RATE: lim_rate = value[RATE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_limits(logic [31:0] g, logic [31:0] s, logic [31:0] r);
		drain();
		write_reg(CFG_GLOBAL, g);
		write_reg(CFG_SUBNET, s);
		write_reg(CFG_RATE, r);
	endtask

	task automatic test_reset_defaults();
		send_packet(32'h00000000, 64'd1000);
		send_packet(32'h00000000, 64'd1010);
		send_packet(32'hFFFFFFFF, 64'd1020);
		send_packet(32'hFFFFFFFF, 64'd1001020);
		send_packet(32'hFFFFFF01, 64'd1001030);
		send_packet(32'h0A000001, 64'd5);
		send_packet(32'h0A000001, 64'd2_000_000_000);
	endtask

	task automatic test_zero_limits();
		set_limits(32'd0, 32'hFFFFFFFF, 32'd1000);
		send_packet(32'h01020304, 64'd10_000_000_000);
		send_packet(32'h05060708, 64'd10_000_000_001);
		set_limits(32'hFFFFFFFF, 32'd0, 32'd1000);
		send_packet(32'h0B0C0D01, 64'd20_000_000_000);
		send_packet(32'h0B0C0D02, 64'd20_000_000_005);
		send_packet(32'h0B0C0D01, 64'd21_500_000_000);
	endtask

	task automatic test_rate_extremes();
		set_limits(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
		send_packet(32'h20000001, 64'd30_000_000_000);
		send_packet(32'h20000001, 64'd30_500_000_000);
		send_packet(32'h20000001, 64'd31_000_000_000);
		set_limits(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_packet(32'h20000002, 64'd32_000_000_000);
		send_packet(32'h20000002, 64'd32_000_000_000);
	endtask

	task automatic test_time_wrap();
		set_limits(32'd50000, 32'd5000, 32'd1000);
		send_packet(32'h30000001, 64'hFFFFFFFFFFFFFFF0);
		send_packet(32'h30000001, 64'h0000000000000010);
		send_packet(32'h30000002, 64'h0000000000000010);
		send_packet(32'h30000001, 64'h0000000000100020);
	endtask

	task automatic test_random_phase(int count, logic [31:0] g, logic [31:0] s, logic [31:0] r);
		int k;
		logic [31:0] addr;
		set_limits(g, s, r);
		clock_ns = {$urandom, $urandom};
		for (k = 0; k < 96; k++)
			host_pool[k] = (k % 6 == 0) ? $urandom : {host_pool[k - (k % 6)][31:8], 8'($urandom)};
		for (k = 0; k < count; k++) begin
			case ($urandom_range(0, 99))
				0: clock_ns = clock_ns - 64'($urandom_range(1, 2_000_000_000));
				1, 2, 3: clock_ns = clock_ns + 64'($urandom_range(1_000_000_000, 1_500_000_000));
				default: clock_ns = clock_ns + 64'($urandom_range(0, 300_000));
			endcase
			addr = ($urandom_range(0, 19) == 0) ? $urandom : host_pool[$urandom_range(0, 95)];
			send_packet(addr, clock_ns);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		src_addr = '0;
		now_ns = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_GLOBAL;
		cfg_data = '0;
		errors = 0;
		lim_global = RST_GLOBAL_LIMIT;
		lim_subnet = RST_SUBNET_LIMIT;
		lim_rate = RST_IP_RATE;
		glb_count = '0;
		glb_start = '0;
		recency = '0;
		sub_fill = 0;
		src_fill = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_zero_limits();
		test_rate_extremes();
		test_time_wrap();
		test_random_phase(350, 32'd50000, 32'd5000, 32'd1000);
		test_random_phase(350, 32'd40, 32'd6, 32'd2000);
		test_random_phase(350, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h3FFFFFFF);
		test_random_phase(350, 32'd120, 32'd0, 32'd0);
		test_random_phase(350, $urandom_range(1, 200), $urandom_range(1, 30),
			$urandom_range(1, 100000));
		drain();
		if (verdict_q.size() != 0) begin
			$error("verdicts still pending at end");
			errors++;
		end
		if (errors == 0) begin
			$display("hierarchical_packet_rate_limiter_tb OK");
		end else begin
			$display("hierarchical_packet_rate_limiter_tb NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
